/* sv/mbd_pkg.sv */
`default_nettype none
package mbd_pkg;

	localparam int PIX_BITS       = 16;
	localparam int PAIR_BITS      = PIX_BITS + 1;
	localparam int QUAD_BITS      = PIX_BITS + 2;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 12;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_HEIGHT = 2'd1;

	typedef enum logic [1:0] {
		OP_LINE_WRITE,
		OP_LINE_ADD,
		OP_DOUBLE
	} cmd_op_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] red;
		logic [PIX_BITS-1:0] green;
		logic [PIX_BITS-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic [PAIR_BITS-1:0] red;
		logic [PAIR_BITS-1:0] green;
		logic [PAIR_BITS-1:0] blue;
	} pair_t;

	typedef struct packed {
		cmd_op_t op;
		logic    last;
		pair_t   sums;
	} cmd_t;

	typedef struct packed {
		logic                      we;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
	} cfg_wr_t;

	typedef struct packed {
		pix_t pix;
		logic last;
	} result_t;

endpackage
`default_nettype wire

/* sv/mbd_in_if.sv */
`default_nettype none
interface mbd_in_if;
	import mbd_pkg::*;

	logic                valid;
	logic                ready;
	logic [PIX_BITS-1:0] red_in;
	logic [PIX_BITS-1:0] green_in;
	logic [PIX_BITS-1:0] blue_in;

	modport source(output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface
`default_nettype wire

/* sv/mbd_out_if.sv */
`default_nettype none
interface mbd_out_if;
	import mbd_pkg::*;

	logic                valid;
	logic                ready;
	logic [PIX_BITS-1:0] red_out;
	logic [PIX_BITS-1:0] green_out;
	logic [PIX_BITS-1:0] blue_out;
	logic                last_pixel;

	modport source(output valid, output red_out, output green_out, output blue_out,
		output last_pixel, input ready);
	modport sink(input valid, input red_out, input green_out, input blue_out,
		input last_pixel, output ready);
endinterface
`default_nettype wire

/* sv/mbd_ram.sv */
`default_nettype none
module mbd_ram #(
	parameter int WIDTH = 51,
	parameter int DEPTH = 1024
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* sv/mbd_queue.sv */
`default_nettype none
module mbd_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PW:0]      wr_ptr_q;
	logic [PW:0]      rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q[PW-1:0]] <= push_data;
		end
	end

	assign empty    = (wr_ptr_q == rd_ptr_q);
	assign full     = (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]) && (wr_ptr_q[PW] != rd_ptr_q[PW]);
	assign pop_data = entries_q[rd_ptr_q[PW-1:0]];
endmodule
`default_nettype wire

/* sv/mbd_front.sv */
`default_nettype none
module mbd_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mbd_pkg::cfg_wr_t  cfg,
	mbd_in_if.sink                 texels,
	input  wire logic              q_full,
	output logic                   q_push,
	output mbd_pkg::cmd_t          cmd,
	output logic [(((MAX_WIDTH + 1) / 2 > 1) ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] cmd_addr
);
	import mbd_pkg::*;

	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int DW = $clog2(MAX_WIDTH + 1);
	localparam int DH = $clog2(MAX_HEIGHT + 1);

	logic [CFG_DATA_BITS-1:0] level_width_q;
	logic [CFG_DATA_BITS-1:0] level_height_q;
	logic [CW-1:0]            col_q;
	logic [RW-1:0]            row_q;
	pix_t                     held_q;

	logic [DW-1:0] w_dim;
	logic [DH-1:0] h_dim;
	logic          w_one;
	logic          h_one;
	logic [CW-1:0] last_col;
	logic [RW-1:0] last_row;
	logic [DH-1:0] pair_rows;
	logic [AW-1:0] last_px;
	logic [RW-1:0] last_py;
	logic [AW-1:0] px;
	logic [RW-1:0] py;
	logic          pair_done;
	logic          cmd_valid;
	logic          accept;
	logic          cfg_hit;
	pix_t          pix;

	// zero acts as one, oversize saturates
	always_comb begin
		if (level_width_q == '0) begin
			w_dim = DW'(1);
		end else if (32'(level_width_q) > 32'(MAX_WIDTH)) begin
			w_dim = DW'(MAX_WIDTH);
		end else begin
			w_dim = DW'(level_width_q);
		end
		if (level_height_q == '0) begin
			h_dim = DH'(1);
		end else if (32'(level_height_q) > 32'(MAX_HEIGHT)) begin
			h_dim = DH'(MAX_HEIGHT);
		end else begin
			h_dim = DH'(level_height_q);
		end
	end

	assign w_one     = (w_dim == DW'(1));
	assign h_one     = (h_dim == DH'(1));
	assign last_col  = CW'(w_dim - DW'(1));
	assign last_row  = RW'(h_dim - DH'(1));
	assign pair_rows = h_dim & ~DH'(1);
	assign last_px   = w_one ? '0 : AW'((w_dim >> 1) - DW'(1));
	assign last_py   = h_one ? '0 : RW'((h_dim >> 1) - DH'(1));

	assign pix.red   = texels.red_in;
	assign pix.green = texels.green_in;
	assign pix.blue  = texels.blue_in;

	assign texels.ready = !q_full;
	assign accept       = texels.valid && texels.ready;
	assign cfg_hit      = cfg.we && ((cfg.index == CFG_LEVEL_WIDTH) ||
		(cfg.index == CFG_LEVEL_HEIGHT));

	assign pair_done = w_one || col_q[0];
	assign px        = w_one ? '0 : AW'(col_q >> 1);
	assign py        = h_one ? '0 : (row_q >> 1);

	always_comb begin
		cmd_valid = 1'b0;
		cmd.op    = OP_LINE_WRITE;
		cmd.last  = (px == last_px) && (py == last_py);
		if (w_one) begin
			cmd.sums.red   = {pix.red, 1'b0};
			cmd.sums.green = {pix.green, 1'b0};
			cmd.sums.blue  = {pix.blue, 1'b0};
		end else begin
			cmd.sums.red   = {1'b0, held_q.red} + {1'b0, pix.red};
			cmd.sums.green = {1'b0, held_q.green} + {1'b0, pix.green};
			cmd.sums.blue  = {1'b0, held_q.blue} + {1'b0, pix.blue};
		end
		if (pair_done && !(w_one && h_one)) begin
			priority if (h_one) begin
				cmd_valid = 1'b1;
				cmd.op    = OP_DOUBLE;
			end else if (DH'(row_q) < pair_rows) begin
				cmd_valid = 1'b1;
				cmd.op    = row_q[0] ? OP_LINE_ADD : OP_LINE_WRITE;
			end else begin
				// odd last row is dropped
				cmd_valid = 1'b0;
			end
		end
	end

	assign q_push   = accept && cmd_valid;
	assign cmd_addr = px;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_width_q  <= CFG_DATA_BITS'(1);
			level_height_q <= CFG_DATA_BITS'(1);
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_hit) begin
			if (cfg.index == CFG_LEVEL_WIDTH) begin
				level_width_q <= cfg.data;
			end else begin
				level_height_q <= cfg.data;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == last_col) begin
				col_q <= '0;
				row_q <= (row_q == last_row) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !pair_done) begin
			held_q <= pix;
		end
	end
endmodule
`default_nettype wire

/* sv/mbd_back.sv */
`default_nettype none
module mbd_back #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire mbd_pkg::cmd_t q_cmd,
	input  wire logic [(((MAX_WIDTH + 1) / 2 > 1) ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] q_addr,
	output logic               q_pop,
	mbd_out_if.source          mip_texels
);
	import mbd_pkg::*;

	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

	logic    valid_s1;
	cmd_t    cmd_s1;
	logic    valid_s2;
	result_t result_s2;

	logic    advance_s1;
	logic    free_s1;
	logic    load_s1;
	logic    ram_we;
	logic    ram_re;
	logic [$bits(pair_t)-1:0] ram_rdata;
	pair_t   line_rd;
	pair_t   addend;
	result_t result;

	function automatic logic [PIX_BITS-1:0] quad_avg(input logic [PAIR_BITS-1:0] a,
		input logic [PAIR_BITS-1:0] b);
		logic [QUAD_BITS-1:0] s;
		s = QUAD_BITS'(a) + QUAD_BITS'(b);
		return s[QUAD_BITS-1:2];
	endfunction

	// line writes retire from the queue head without entering the pipe
	assign advance_s1 = valid_s1 && (!valid_s2 || mip_texels.ready);
	assign free_s1    = !valid_s1 || advance_s1;
	assign q_pop      = !q_empty && ((q_cmd.op == OP_LINE_WRITE) || free_s1);
	assign ram_we     = q_pop && (q_cmd.op == OP_LINE_WRITE);
	assign ram_re     = q_pop && (q_cmd.op == OP_LINE_ADD);
	assign load_s1    = q_pop && (q_cmd.op != OP_LINE_WRITE);

	mbd_ram #(
		.WIDTH($bits(pair_t)),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_addr),
		.wdata(q_cmd.sums),
		.re   (ram_re),
		.raddr(q_addr),
		.rdata(ram_rdata)
	);

	assign line_rd = pair_t'(ram_rdata);

	always_comb begin
		unique case (cmd_s1.op)
			OP_LINE_ADD: addend = line_rd;
			OP_DOUBLE:   addend = cmd_s1.sums;
			default:     addend = cmd_s1.sums;
		endcase
		result.pix.red   = quad_avg(cmd_s1.sums.red, addend.red);
		result.pix.green = quad_avg(cmd_s1.sums.green, addend.green);
		result.pix.blue  = quad_avg(cmd_s1.sums.blue, addend.blue);
		result.last      = cmd_s1.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
			if (!valid_s2 || mip_texels.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1 <= q_cmd;
		end
		if (advance_s1) begin
			result_s2 <= result;
		end
	end

	assign mip_texels.valid      = valid_s2;
	assign mip_texels.red_out    = result_s2.pix.red;
	assign mip_texels.green_out  = result_s2.pix.green;
	assign mip_texels.blue_out   = result_s2.pix.blue;
	assign mip_texels.last_pixel = result_s2.last;
endmodule
`default_nettype wire

/* sv/mipmap_box_downsample_top.sv */
`default_nettype none
// 2x2 box-filter mip reducer. Takes one RGB texel of the input level per
// cycle in raster order and streams out the next level, max(1,W/2) by
// max(1,H/2) (none for a 1x1 level), each channel the truncated mean of
// four; last_pixel marks the final texel of the output level. The front end
// accepts one texel every cycle while its four-entry command queue has room;
// the back end retires one command per cycle unless the output stalls, with
// at most one line-store access (write of an even-row pair sum or read of
// one for the odd row; a height-one pair needs none), so the sustained rate
// is one texel per cycle. A result passes through the queue, the s1 command
// register and the s2 result register before it is offered. The line store
// holds (MAX_WIDTH+1)/2 entries of three 17-bit pair sums, is not cleared,
// and needs no clearing pass. Any write to level_width or level_height
// restarts the level at (0,0); program them only while the block is idle.
module mipmap_box_downsample_top #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [mbd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [mbd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	mbd_in_if.sink                                  texels,
	mbd_out_if.source                               mip_texels
);
	import mbd_pkg::*;

	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int QW = AW + $bits(cmd_t);

	cfg_wr_t       cfg;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	cmd_t          push_cmd;
	logic [AW-1:0] push_addr;
	cmd_t          head_cmd;
	logic [AW-1:0] head_addr;
	logic [QW-1:0] head_data;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	mbd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.texels  (texels),
		.q_full  (q_full),
		.q_push  (q_push),
		.cmd     (push_cmd),
		.cmd_addr(push_addr)
	);

	mbd_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({push_addr, push_cmd}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (head_data),
		.empty    (q_empty)
	);

	assign head_addr = head_data[QW-1:$bits(cmd_t)];
	assign head_cmd  = cmd_t'(head_data[$bits(cmd_t)-1:0]);

	mbd_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (head_cmd),
		.q_addr    (head_addr),
		.q_pop     (q_pop),
		.mip_texels(mip_texels)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into a full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from an empty queue");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> !q_empty)
		else $error("pushed command missing from queue");
endmodule
`default_nettype wire
